>>> rtl/core/pbdl_pkg.sv
package pbdl_pkg;

    // Pin and tick sizing
    localparam int NUM_PINS       = 14;
    localparam int TOP_BUTTON_PIN = 6;
    localparam int DREQ_PIN_INDEX = 7;
    localparam int TICK_WIDTH     = 32;

    // Fixed field widths
    localparam int GAP_W   = 32;
    localparam int INDEX_W = 4;
    localparam int PIN_W   = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Register map: byte address bit 2 selects the register slot
    localparam logic REG_MIN_GAP = 1'b0;
    localparam logic [GAP_W-1:0] MIN_GAP_RESET = GAP_W'(200);

    // Only pins that exist can be scanned
    localparam int SCAN_CELLS = (TOP_BUTTON_PIN < NUM_PINS) ? TOP_BUTTON_PIN + 1 : NUM_PINS;

    // Width used for the gap compare
    localparam int CMP_W = (TICK_WIDTH > GAP_W) ? TICK_WIDTH : GAP_W;

    typedef logic [NUM_PINS-1:0]   pin_mask_t;
    typedef logic [SCAN_CELLS-1:0] scan_mask_t;
    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [GAP_W-1:0]      gap_t;

    // Clear bit of the data-request pin (zero when that pin does not exist)
    localparam pin_mask_t DREQ_MASK = pin_mask_t'(1) << DREQ_PIN_INDEX;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic               dreq;
        logic               found;
        logic [PIN_W-1:0]   pin;
        logic [INDEX_W-1:0] idx;
        scan_mask_t         pend;
        scan_mask_t         clr;
        tick_t              now;
    } token_t;

endpackage

>>> rtl/core/pbdl_cell.sv
module pbdl_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  pbdl_pkg::gap_t  min_gap,
    input  pbdl_pkg::token_t tok_in,
    output pbdl_pkg::token_t tok_out
);
    import pbdl_pkg::*;

    tick_t            ts_reg;
    tick_t            ts_next;
    token_t           tok_reg;
    token_t           tok_next;
    logic             hit;
    logic             accept;
    tick_t            diff;

    // Debounce check for the pin the token is visiting
    assign hit    = tok_in.vld && !tok_in.found && tok_in.pend[SCAN_CELLS-1];
    assign diff   = tok_in.now - ts_reg;
    assign accept = hit && (CMP_W'(diff) >= CMP_W'(min_gap));

    // Token update: drop the visited pin, record its clear bit, step down one pin
    always_comb
    begin
        tok_next      = tok_in;
        tok_next.pend = tok_in.pend << 1;
        tok_next.clr  = (tok_in.clr << 1) | SCAN_CELLS'(hit);
        tok_next.pin  = tok_in.pin - PIN_W'(1);
        ts_next       = ts_reg;
        if (accept)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = tok_in.pin[INDEX_W-1:0];
            ts_next        = tok_in.now;
        end
    end

    // Timestamp of this pin's last accepted press
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= '0;
        end
        else if (advance)
        begin
            ts_reg <= ts_next;
        end
    end

    // Token register toward the next lower pin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/priority_button_debounce_lockout_unit.sv
// The scan token walks the cell row one pin per cycle while the row is not stalled,
//   and the output register takes the result as it leaves the row; a new item enters
//   only once the previous one has left the row.
// A held output stalls the row; a new item may be taken while a result waits.
// Reset: all pin timestamps cleared to zero, min_gap set to 200, no item in flight.
module priority_button_debounce_lockout_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pbdl_pkg::NUM_PINS-1:0] pending_rises,
    input  logic [pbdl_pkg::TICK_WIDTH-1:0] now_tick,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          dreq_event,
    output logic                          button_valid,
    output logic [pbdl_pkg::INDEX_W-1:0]  button_index,
    output logic [pbdl_pkg::NUM_PINS-1:0] clear_mask,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbdl_pkg::ADDR_W-1:0]   paddr,
    input  logic [pbdl_pkg::DATA_W-1:0]   pwdata,
    output logic [pbdl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import pbdl_pkg::*;

    gap_t      min_gap_reg;
    logic      busy_reg;
    logic      busy_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      dreq_reg;
    logic      valid_reg;
    logic [INDEX_W-1:0] index_reg;
    pin_mask_t clr_reg;

    logic      accept_in;
    logic      advance;
    logic      load_out;
    pin_mask_t dreq_sh;
    logic      dreq_pend;
    token_t    entry_tok;
    token_t    chain_tok [SCAN_CELLS+1];
    token_t    tail;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_GAP) ? DATA_W'(min_gap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= MIN_GAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_GAP))
        begin
            min_gap_reg <= pwdata[GAP_W-1:0];
        end
    end

    // Entry: data request bypasses the button scan
    assign in_ready  = !busy_reg;
    assign accept_in = in_valid && in_ready;
    assign dreq_sh   = pending_rises >> DREQ_PIN_INDEX;
    assign dreq_pend = dreq_sh[0];

    always_comb
    begin
        entry_tok       = '0;
        entry_tok.vld   = accept_in;
        entry_tok.dreq  = dreq_pend;
        entry_tok.pin   = PIN_W'(SCAN_CELLS - 1);
        entry_tok.pend  = dreq_pend ? '0 : pending_rises[SCAN_CELLS-1:0];
        entry_tok.now   = now_tick;
    end

    // Row stalls only when a finished token cannot enter the output register
    assign tail     = chain_tok[0];
    assign advance  = !(tail.vld && out_valid_reg && !out_ready);
    assign load_out = advance && tail.vld;

    assign chain_tok[SCAN_CELLS] = entry_tok;

    // Cell row, top scanned pin first
    for (genvar k = 0; k < SCAN_CELLS; k++)
    begin : g_cell
        pbdl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .min_gap (min_gap_reg),
            .tok_in  (chain_tok[k+1]),
            .tok_out (chain_tok[k])
        );
    end

    // Busy while an item is in the row
    always_comb
    begin
        busy_next = busy_reg;
        if (accept_in)
        begin
            busy_next = 1'b1;
        end
        else if (load_out)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dreq_reg  <= tail.dreq;
            valid_reg <= tail.found;
            index_reg <= tail.found ? tail.idx : '0;
            clr_reg   <= NUM_PINS'(tail.clr) | (tail.dreq ? DREQ_MASK : '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign dreq_event   = dreq_reg;
    assign button_valid = valid_reg;
    assign button_index = index_reg;
    assign clear_mask   = clr_reg;

endmodule
